### design/slins_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slins_pkg
// Shared widths, result status codes and the cell control word of the
// sorted list insert unit.
// ----------------------------------------------------------------------------
package slins_pkg;

    localparam int KEY_W         = 32;
    localparam int STATUS_W      = 2;
    localparam int DEPTH_DEFAULT = 16;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ENTRY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;   // place the new key, shifting keys not smaller up
        logic rotate;   // every cell takes its upper neighbor's contents
    } cell_ctrl_t;

endpackage

### design/slins_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slins_cell
// One slot of the sorted chain: holds a key and its valid bit, compares
// against the broadcast key and takes either the new key, its lower
// neighbor's key or its upper neighbor's key.
// ----------------------------------------------------------------------------
module slins_cell
    import slins_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cell_ctrl_t              ctrl,
    input  logic signed [KEY_W-1:0] new_key,
    input  logic signed [KEY_W-1:0] lower_key,
    input  logic                    lower_valid,
    input  logic                    lower_ins,
    input  logic signed [KEY_W-1:0] upper_key,
    input  logic                    upper_valid,
    output logic signed [KEY_W-1:0] key,
    output logic                    valid,
    output logic                    ins
);

    logic signed [KEY_W-1:0] key_reg, key_next;
    logic                    valid_reg, valid_next;

    // The new key belongs here or below when this slot is empty or holds a
    // key that is not smaller.
    assign ins = !valid_reg || !(key_reg < new_key);

    always_comb begin
        key_next   = key_reg;
        valid_next = valid_reg;
        if (ctrl.rotate) begin
            key_next   = upper_key;
            valid_next = upper_valid;
        end else if (ctrl.insert && ins) begin
            key_next   = lower_ins ? lower_key : new_key;
            valid_next = valid_reg | lower_valid;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign key   = key_reg;
    assign valid = valid_reg;

endmodule

### design/sorted_list_insert_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_insert_unit
// Ordered store of up to DEPTH signed keys built as a chain of insertion
// cells.
// ----------------------------------------------------------------------------
// Input words arrive on s_axis: s_tuser is the operation (0 insert, 1 dump),
// s_tdata the signed key. Results leave on m_axis: m_tdata is the key on a
// list entry (zero otherwise), m_tuser the status (0 inserted, 1 dropped
// because full, 2 list entry, 3 list empty), m_tlast marks the final word
// of the results for one input word.
// An insert compares the key in every cell at once and shifts the keys not
// smaller up one cell, so one insert is taken each cycle while idle and the
// output is free; its result word is registered and shows the next cycle.
// A dump rotates the whole chain through cell 0, one cell per cycle
// unless paused, and no input word is accepted until the rotation ends;
// the stored keys leave smallest first, one word per rotation step. A dump
// of an empty store gives one list-empty word in the cycle after acceptance.
// While a word waits on a low m_tready the output register holds it,
// input is not accepted and a running dump pauses on steps that emit a word.
// Reset (aresetn low at a clock edge) empties the store and the output.
// ----------------------------------------------------------------------------
module sorted_list_insert_unit
    import slins_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [KEY_W-1:0]    s_tdata,    // [31:0] key
    input  logic                s_tuser,    // [0] operation
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [KEY_W-1:0]    m_tdata,    // [31:0] key_out
    output logic [STATUS_W-1:0] m_tuser,    // [1:0] status
    output logic                m_tlast
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int RW = $clog2(DEPTH);
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DUMP = 1'b1;

    logic                state_reg, state_next;
    logic [RW-1:0]       rot_reg, rot_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [KEY_W-1:0]    m_tdata_reg, m_tdata_next;
    logic [STATUS_W-1:0] m_tuser_reg, m_tuser_next;
    logic                m_tlast_reg, m_tlast_next;

    logic signed [KEY_W-1:0] cell_key   [DEPTH];
    logic                    cell_valid [DEPTH];
    logic                    cell_ins   [DEPTH];

    cell_ctrl_t ctrl;
    logic       out_free, accept, full, dump_op, do_insert, start_dump;
    logic       rot_in_list, emit_dump, step;

    assign out_free    = !m_tvalid_reg || m_tready;
    assign s_tready    = (state_reg == ST_IDLE) && out_free;
    assign accept      = s_tvalid && s_tready;
    assign full        = (count_reg == CW'(DEPTH));
    assign dump_op     = s_tuser;
    assign do_insert   = accept && !dump_op && !full;
    assign start_dump  = accept && dump_op && (count_reg != '0);
    assign rot_in_list = (CW'(rot_reg) < count_reg);
    assign emit_dump   = (state_reg == ST_DUMP) && rot_in_list && out_free;
    // Steps past the stored keys only restore the order and never wait.
    assign step        = (state_reg == ST_DUMP) && (out_free || !rot_in_list);

    assign ctrl.insert = do_insert;
    assign ctrl.rotate = step;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic signed [KEY_W-1:0] lower_key;
        logic                    lower_valid;
        logic                    lower_ins;
        if (i == 0) begin : g_first
            assign lower_key   = '0;
            assign lower_valid = 1'b1;
            assign lower_ins   = 1'b0;
        end else begin : g_rest
            assign lower_key   = cell_key[i-1];
            assign lower_valid = cell_valid[i-1];
            assign lower_ins   = cell_ins[i-1];
        end

        slins_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .new_key     (s_tdata),
            .lower_key   (lower_key),
            .lower_valid (lower_valid),
            .lower_ins   (lower_ins),
            .upper_key   (cell_key[(i + 1) % DEPTH]),
            .upper_valid (cell_valid[(i + 1) % DEPTH]),
            .key         (cell_key[i]),
            .valid       (cell_valid[i]),
            .ins         (cell_ins[i])
        );
    end

    always_comb begin
        state_next = state_reg;
        rot_next   = rot_reg;
        count_next = count_reg;
        if (do_insert) begin
            count_next = count_reg + 1'b1;
        end
        if (start_dump) begin
            state_next = ST_DUMP;
            rot_next   = '0;
        end else if (step) begin
            if (rot_reg == RW'(DEPTH - 1)) begin
                state_next = ST_IDLE;
            end
            rot_next = rot_reg + 1'b1;
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        if (out_free) begin
            m_tvalid_next = (accept && !start_dump) || emit_dump;
            m_tdata_next  = '0;
            m_tlast_next  = 1'b1;
            if (emit_dump) begin
                m_tdata_next = cell_key[0];
                m_tuser_next = ST_ENTRY;
                m_tlast_next = (CW'(rot_reg) == count_reg - 1'b1);
            end else if (dump_op) begin
                m_tuser_next = ST_EMPTY;
            end else begin
                m_tuser_next = full ? ST_DROPPED : ST_INSERTED;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rot_reg     <= rot_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

### design/slins_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slins_checker
// Port-level checks of the sorted list insert unit, bound to the top level.
// ----------------------------------------------------------------------------
module slins_checker
    import slins_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [KEY_W-1:0]    m_tdata,
    input logic [STATUS_W-1:0] m_tuser,
    input logic                m_tlast
);

    // A stalled result word keeps its contents.
    a_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tuser) && $stable(m_tlast))
        else $error("result word changed while stalled");

    // Only list entries may come without the last marker.
    a_single_last : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_INSERTED || m_tuser == ST_DROPPED
                     || m_tuser == ST_EMPTY) |-> m_tlast)
        else $error("single result word without last marker");

    // Words other than list entries carry a zero key.
    a_zero_key : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_ENTRY |-> m_tdata == '0)
        else $error("nonzero key on a status word");

    // Reset leaves no result pending.
    a_reset_out : assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word present after reset");

endmodule

bind sorted_list_insert_unit slins_checker u_slins_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
